FILE: rtl/core/lsd_pkg.sv
package lsd_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_DUMP = 2'd2,
        KIND_PEEK = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DATA  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR_EMPTY,
        ST_ERR_FULL,
        ST_PEEK_OUT,
        ST_DUMP_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic push;       // write push word at the fill level, count up
        logic pop;        // count down
        logic rd_top;     // read the top entry
        logic rd_next;    // read the entry below the last one read
        logic load_data;  // load read word into the output register
        logic data_last;  // last flag for a data result
        logic load_err;   // load an error result into the output register
        logic err_full;   // error kind: full when set, empty otherwise
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic ptr_zero;   // last read was the bottom entry
        logic slot_free;  // output register can take a result this cycle
    } stat_t;

endpackage

FILE: rtl/core/lsd_ctrl.sv
module lsd_ctrl
    import lsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  in_kind,
    output logic        in_ready,
    input  stat_t       stat,
    output cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;
    kind_t  kind;

    assign kind = kind_t'(in_kind);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_PUSH)
                    begin
                        if (stat.full)
                        begin
                            state_next = ST_ERR_FULL;
                        end
                    end
                    else if (stat.empty)
                    begin
                        state_next = ST_ERR_EMPTY;
                    end
                    else if (kind == KIND_PEEK)
                    begin
                        state_next = ST_PEEK_OUT;
                    end
                    else if (kind == KIND_DUMP)
                    begin
                        state_next = ST_DUMP_OUT;
                    end
                end
            end
            ST_ERR_EMPTY, ST_ERR_FULL, ST_PEEK_OUT:
            begin
                if (stat.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP_OUT:
            begin
                if (stat.slot_free && stat.ptr_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.push    = in_valid && (kind == KIND_PUSH) && !stat.full;
                cmd.pop     = in_valid && (kind == KIND_POP) && !stat.empty;
                cmd.rd_top  = in_valid && !stat.empty
                              && ((kind == KIND_PEEK) || (kind == KIND_DUMP));
            end
            ST_ERR_EMPTY:
            begin
                cmd.load_err = stat.slot_free;
            end
            ST_ERR_FULL:
            begin
                cmd.load_err = stat.slot_free;
                cmd.err_full = 1'b1;
            end
            ST_PEEK_OUT:
            begin
                cmd.load_data = stat.slot_free;
                cmd.data_last = 1'b1;
            end
            ST_DUMP_OUT:
            begin
                cmd.load_data = stat.slot_free;
                cmd.data_last = stat.ptr_zero;
                cmd.rd_next   = stat.slot_free && !stat.ptr_zero;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/lsd_dpath.sv
module lsd_dpath
    import lsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] push_value,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word,
    output logic [1:0]        out_status,
    output logic              out_last
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  fill_dec;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [WORD_W-1:0] rd_data_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    status_t           out_status_reg;
    logic              out_last_reg;

    assign fill_dec       = fill_reg - CNT_W'(1);
    assign stat.empty     = (fill_reg == '0);
    assign stat.full      = (fill_reg == CNT_W'(DEPTH));
    assign stat.ptr_zero  = (ptr_reg == '0);
    assign stat.slot_free = !out_valid_reg || out_ready;

    assign rd_en   = cmd.rd_top || cmd.rd_next;
    assign rd_addr = cmd.rd_top ? fill_dec[ADDR_W-1:0] : (ptr_reg - ADDR_W'(1));

    always_comb
    begin
        fill_next = fill_reg;
        priority if (cmd.push)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            fill_next = fill_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // stack store with one write and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            ptr_reg     <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_data || cmd.load_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_data)
        begin
            out_word_reg   <= rd_data_reg;
            out_status_reg <= STATUS_DATA;
            out_last_reg   <= cmd.data_last;
        end
        else if (cmd.load_err)
        begin
            out_word_reg   <= '0;
            out_status_reg <= cmd.err_full ? STATUS_FULL : STATUS_EMPTY;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_word   = out_word_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.full)
        else $error("push issued on a full stack");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop issued on an empty stack");

    a_rd_next_above_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_next |-> !stat.ptr_zero && !cmd.rd_top)
        else $error("dump read walked below the bottom entry");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_data || cmd.load_err) |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond stack depth");

endmodule

FILE: rtl/core/lifo_stack_with_dump.sv
// LIFO stack of DEPTH signed 32-bit words with push, pop, peek and dump.
// The operation rides in s_axis_tuser (0 push, 1 pop, 2 dump, 3 peek) and
// the push word in s_axis_tdata. Push and a successful pop produce no
// result and are accepted back to back. Peek does a registered read of
// the store, then the output load. Dump streams every stored word top to
// bottom through the one read port, with m_axis_tlast on the bottom word.
// Pop, peek or dump on an empty stack, and push on a full one, produce a
// single error transfer (word zero, m_axis_tuser = 1 empty or 2 full,
// tlast set) and leave the stack unchanged. Each output load waits while
// the output register holds an untaken result and m_axis_tready is low.
// Results leave through an output register, so a pending result never
// blocks the decode of the next item except while that item needs the
// output slot. The store has no reset; only words written by a push are
// ever read.
module lifo_stack_with_dump
    import lsd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] word
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    cmd_t  cmd;
    stat_t stat;

    // Sequence each item: decode, read the store, load the output register.
    lsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the store, fill count, dump pointer and output register.
    lsd_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_value (s_axis_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (m_axis_tdata),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

FILE: dv/tb_lifo_stack_with_dump.sv
`timescale 1ns / 1ps

module tb_lifo_stack_with_dump;
    import lsd_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;

    // One result transfer as seen on the master side.
    typedef struct packed {
        logic [31:0] word;
        status_t     status;
        logic        last;
    } result_t;

    // One row of the directed table. When hand_checked is set, the row gives
    // its single result directly and the predictor only tracks the stack.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic        hand_checked;
        logic [31:0] word;
        status_t     status;
    } op_row_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = KIND_PUSH;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predicted stack contents and the results still owed by the block.
    logic [31:0] model_words [STACK_DEPTH];
    int          model_fill = 0;
    result_t     owed_results [$];

    int          fail_count   = 0;
    int          sender_gap_pct   = 0;
    int          receiver_gap_pct = 0;

    // Directed opening: empty errors, extremes of the word, every kind,
    // a one-word dump and a pop that ignores its data field.
    op_row_t directed_ops [0:21] = '{
        '{KIND_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_PEEK, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_DUMP, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_PUSH, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_PEEK, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STATUS_DATA},
        '{KIND_PUSH, 32'h8000_0000, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_PEEK, 32'h0000_0000, 1'b1, 32'h8000_0000, STATUS_DATA},
        '{KIND_PUSH, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_PUSH, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_DUMP, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_PEEK, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, STATUS_DATA},
        '{KIND_POP,  32'hAAAA_AAAA, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_DUMP, 32'h5555_5555, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_PEEK, 32'h5555_5555, 1'b1, 32'h8000_0000, STATUS_DATA},
        '{KIND_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_POP,  32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_DUMP, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY},
        '{KIND_PUSH, 32'h1234_5678, 1'b0, 32'h0000_0000, STATUS_DATA},
        '{KIND_DUMP, 32'h0000_0000, 1'b1, 32'h1234_5678, STATUS_DATA},
        '{KIND_POP,  32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_DATA}
    };

    lifo_stack_with_dump u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] push_value
        .s_axis_tuser  (s_axis_tuser),   // [1:0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] word
        .m_axis_tuser  (m_axis_tuser),   // [1:0] status
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Advance the predicted stack by one accepted operation and return the
    // results it owes, in the order the block must send them.
    function automatic void predict_stack_op(input kind_t kind, input logic [31:0] value,
                                             output result_t outs [$]);
        int idx;
        outs = {};
        if (kind == KIND_PUSH)
        begin
            if (model_fill == STACK_DEPTH)
                outs.push_back('{32'd0, STATUS_FULL, 1'b1});
            else
            begin
                model_words[model_fill] = value;
                model_fill++;
            end
        end
        else if (model_fill == 0)
            outs.push_back('{32'd0, STATUS_EMPTY, 1'b1});
        else if (kind == KIND_POP)
            model_fill--;
        else if (kind == KIND_PEEK)
            outs.push_back('{model_words[model_fill - 1], STATUS_DATA, 1'b1});
        else
        begin
            // dump walks from the top entry down, tlast only on the bottom one
            for (idx = model_fill - 1; idx >= 0; idx--)
                outs.push_back('{model_words[idx], STATUS_DATA, (idx == 0)});
        end
    endfunction

    // Pick an operation, steering the fill level away from empty and from growing past 20.
    function automatic kind_t pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (model_fill == 0)
            return (roll < 60) ? KIND_PUSH : kind_t'($urandom_range(1, 3));
        if (model_fill > 20)
            return (roll < 25) ? KIND_PUSH : (roll < 70) ? KIND_POP :
                   (roll < 90) ? KIND_PEEK : KIND_DUMP;
        return (roll < 40) ? KIND_PUSH : (roll < 70) ? KIND_POP :
               (roll < 90) ? KIND_PEEK : KIND_DUMP;
    endfunction

    // Mix the corner words in with fully random ones.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Present one operation, hold it until the transfer happens, then queue
    // the results it owes. A hand-checked row supplies its own single result.
    task automatic issue_op(input kind_t kind, input logic [31:0] value,
                            input logic hand_checked, input logic [31:0] word,
                            input status_t status);
        result_t outs [$];
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_stack_op(kind, value, outs);
        if (hand_checked)
            owed_results.push_back('{word, status, 1'b1});
        else
            foreach (outs[i])
                owed_results.push_back(outs[i]);
    endtask

    task automatic issue_random(input kind_t kind);
        issue_op(kind, pick_word(), 1'b0, 32'd0, STATUS_DATA);
    endtask

    // Hold off the sender until every owed result has been transferred.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: check each transfer against the oldest owed result, then
    // decide whether to stall the next cycle.
    always @(posedge clk)
    begin
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (owed_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: unexpected result word=%h status=%0d last=%0b",
                             $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (m_axis_tdata !== want.word || m_axis_tuser !== want.status ||
                    m_axis_tlast !== want.last)
                begin
                    if (fail_count < 10)
                        $display("%0t: result mismatch: expected word=%h status=%0d last=%0b,",
                                 $realtime, want.word, want.status, want.last,
                                 " got word=%h status=%0d last=%0b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_gap_pct);
    end

    initial
    begin
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling on either side.
        foreach (directed_ops[i])
            issue_op(directed_ops[i].kind, directed_ops[i].value,
                     directed_ops[i].hand_checked, directed_ops[i].word,
                     directed_ops[i].status);
        drain_results();

        // Phase one: sender mostly busy, receiver stalls about half the time.
        sender_gap_pct   = 7;
        receiver_gap_pct = 53;
        for (n = 0; n < 40; n++)
            issue_random(pick_kind());
        drain_results();

        // Phase two: roles swapped. Fill to the top, push against the full
        // stack, read it all back, then wander near the top.
        sender_gap_pct   = 53;
        receiver_gap_pct = 7;
        while (model_fill < STACK_DEPTH)
            issue_random(KIND_PUSH);
        repeat (3) issue_random(KIND_PUSH);
        issue_random(KIND_PEEK);
        issue_random(KIND_DUMP);
        for (n = 0; n < 12; n++)
            issue_random(($urandom_range(0, 1) == 0) ? KIND_PUSH : kind_t'($urandom_range(1, 3)));
        drain_results();

        // Phase three: no idling at all, then drain the stack, pop once more and dump.
        sender_gap_pct   = 0;
        receiver_gap_pct = 0;
        for (n = 0; n < 30; n++)
            issue_random(pick_kind());
        while (model_fill > 0)
            issue_random(KIND_POP);
        issue_random(KIND_POP);
        issue_random(KIND_DUMP);

        drain_results();
        // Leave room for any stray transfer after the last owed one.
        repeat (20) @(posedge clk);
        if (fail_count == 0 && owed_results.size() == 0)
            $display("lifo_stack_with_dump regression: pass");
        else
            $display("lifo_stack_with_dump regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("lifo_stack_with_dump regression: fail");
        $finish;
    end

endmodule
